/* hw/rtl/sba_pkg.sv */
// Package for the sprite batch triangle assembler.
// Holds the beat structs, the per-item result record and the mode and kind codes.
// No dependencies; every RTL file of the block refers to it by scoped names.
`default_nettype none

package sba_pkg;

  localparam int BATCH_CAPACITY_DEF = 1024;

  localparam logic FUNC_VERTEX = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  localparam logic [1:0] MODE_FAN   = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_LIST  = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  localparam logic [3:0] SPRITE_CNT_MIN = 4'd3;
  localparam logic [3:0] SPRITE_CNT_MAX = 4'd8;
  localparam logic [4:0] TRI_VERTS      = 5'd3;
  localparam logic [4:0] TRI_OVERHEAD   = 5'd2;

  localparam logic [1:0] NVERT_NONE = 2'd0;
  localparam logic [1:0] NVERT_ONE  = 2'd1;
  localparam logic [1:0] NVERT_TRI  = 2'd3;

  typedef struct packed {
    logic        func;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [15:0] texture_id;
    logic [31:0] color_key;
    logic [1:0]  primitive_mode;
    logic [3:0]  sprite_vertex_count;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_u;
    logic [31:0] out_v;
    logic [15:0] batch_texture;
    logic [31:0] batch_color;
    logic [10:0] batch_vertices;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] u;
    logic [31:0] v;
  } vertex_t;

  // Everything one input item produces: an optional draw command, then 0, 1 or 3 vertices.
  typedef struct packed {
    logic              has_draw;
    logic [1:0]        nvert;
    logic [15:0]       draw_tex;
    logic [31:0]       draw_col;
    logic [10:0]       draw_cnt;
    vertex_t [2:0]     vtx;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/sba_assemble.sv */
// Assembly stage: sprite position tracking, saved vertices and batch bookkeeping.
// Turns each accepted input beat into a job record in one pass. Uses sba_pkg.
`default_nettype none

module sba_assemble #(
  parameter int BATCH_CAPACITY = sba_pkg::BATCH_CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire sba_pkg::in_beat_t in_beat,
  output sba_pkg::job_t         job,
  output logic                  job_nonempty
);

  // Batch never grows past capacity plus one fan or strip sprite.
  localparam int CW = $clog2(BATCH_CAPACITY + 32);

  logic [2:0]             pos_r, pos_nxt;
  logic [CW-1:0]          bcount_r, bcount_nxt;
  logic [15:0]            btex_r, btex_nxt;
  logic [31:0]            bcol_r, bcol_nxt;
  logic [3:0]             scount_r, scount_nxt;
  logic [1:0]             smode_r, smode_nxt;
  sba_pkg::vertex_t       first_r, first_nxt;
  sba_pkg::vertex_t       two_r, two_nxt;
  sba_pkg::vertex_t       prev_r, prev_nxt;

  sba_pkg::vertex_t cur;
  logic             is_flush;
  logic             first_v;
  logic [3:0]       cnt_sat;
  logic [3:0]       cnt_eff;
  logic [1:0]       mode_eff;
  logic [4:0]       extra;
  logic [CW:0]      cap_sum;
  logic             over;
  logic             do_draw;
  logic [1:0]       nvert;
  logic [CW-1:0]    bc_base;

  always_comb begin
    cur.x = in_beat.pos_x;
    cur.y = in_beat.pos_y;
    cur.u = in_beat.tex_u;
    cur.v = in_beat.tex_v;

    is_flush = (in_beat.func == sba_pkg::FUNC_FLUSH);
    first_v  = (pos_r == 3'd0);

    if (in_beat.sprite_vertex_count < sba_pkg::SPRITE_CNT_MIN) begin
      cnt_sat = sba_pkg::SPRITE_CNT_MIN;
    end else if (in_beat.sprite_vertex_count > sba_pkg::SPRITE_CNT_MAX) begin
      cnt_sat = sba_pkg::SPRITE_CNT_MAX;
    end else begin
      cnt_sat = in_beat.sprite_vertex_count;
    end

    cnt_eff  = first_v ? cnt_sat : scount_r;
    mode_eff = first_v ? in_beat.primitive_mode : smode_r;

    extra   = 5'(({1'b0, cnt_sat} - sba_pkg::TRI_OVERHEAD) * sba_pkg::TRI_VERTS);
    cap_sum = (CW+1)'(bcount_r) + (CW+1)'(extra);
    over    = (cap_sum >= (CW+1)'(BATCH_CAPACITY));

    if (is_flush) begin
      do_draw = (bcount_r != '0);
    end else begin
      do_draw = (bcount_r != '0) && first_v &&
                ((in_beat.texture_id != btex_r) || (in_beat.color_key != bcol_r) || over);
    end

    if (is_flush) begin
      nvert = sba_pkg::NVERT_NONE;
    end else if (mode_eff == sba_pkg::MODE_LIST) begin
      nvert = sba_pkg::NVERT_ONE;
    end else if (((mode_eff == sba_pkg::MODE_FAN) || (mode_eff == sba_pkg::MODE_STRIP)) &&
                 (pos_r >= 3'd2)) begin
      nvert = sba_pkg::NVERT_TRI;
    end else begin
      nvert = sba_pkg::NVERT_NONE;
    end

    job.has_draw = do_draw;
    job.nvert    = nvert;
    job.draw_tex = btex_r;
    job.draw_col = bcol_r;
    job.draw_cnt = 11'(bcount_r);
    if (mode_eff == sba_pkg::MODE_LIST) begin
      job.vtx[0] = cur;
    end else if (mode_eff == sba_pkg::MODE_FAN) begin
      job.vtx[0] = first_r;
    end else begin
      job.vtx[0] = two_r;
    end
    job.vtx[1] = prev_r;
    job.vtx[2] = cur;

    job_nonempty = do_draw || (nvert != sba_pkg::NVERT_NONE);

    bc_base    = do_draw ? '0 : bcount_r;
    bcount_nxt = bc_base + CW'(nvert);

    btex_nxt   = btex_r;
    bcol_nxt   = bcol_r;
    scount_nxt = scount_r;
    smode_nxt  = smode_r;
    first_nxt  = first_r;
    two_nxt    = two_r;
    prev_nxt   = prev_r;
    pos_nxt    = pos_r;
    if (!is_flush) begin
      if (first_v) begin
        btex_nxt   = in_beat.texture_id;
        bcol_nxt   = in_beat.color_key;
        scount_nxt = cnt_sat;
        smode_nxt  = in_beat.primitive_mode;
        first_nxt  = cur;
      end
      // previous becomes two back, current becomes previous
      two_nxt  = prev_r;
      prev_nxt = cur;
      if (({1'b0, pos_r} + 4'd1) >= cnt_eff) begin
        pos_nxt = 3'd0;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      bcount_r <= '0;
      btex_r   <= '0;
      bcol_r   <= '0;
      scount_r <= '0;
      smode_r  <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      bcount_r <= bcount_nxt;
      btex_r   <= btex_nxt;
      bcol_r   <= bcol_nxt;
      scount_r <= scount_nxt;
      smode_r  <= smode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
      two_r   <= two_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sba_emit.sv */
// Emit stage: holds one job record and sends its results, one beat per cycle
// while out_stall is low, through the output register. Uses sba_pkg.
`default_nettype none

module sba_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_load,
  input  wire sba_pkg::job_t job_in,
  output logic               job_free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sba_pkg::out_beat_t out_data
);

  sba_pkg::job_t      job_r, job_nxt;
  logic               job_valid_r, job_valid_nxt;
  logic [1:0]         idx_r, idx_nxt;
  sba_pkg::out_beat_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic       out_load;
  logic [2:0] total;
  logic       is_last;
  logic       is_draw;
  logic [1:0] vsel;

  always_comb begin
    out_load = !out_valid_r || !out_stall;
    total    = 3'(job_r.has_draw) + 3'(job_r.nvert);
    is_last  = ({1'b0, idx_r} == (total - 3'd1));
    is_draw  = job_r.has_draw && (idx_r == 2'd0);
    vsel     = idx_r - 2'(job_r.has_draw);

    job_free = !job_valid_r || (out_load && is_last);

    if (is_draw) begin
      out_nxt.kind           = sba_pkg::KIND_DRAW;
      out_nxt.out_x          = '0;
      out_nxt.out_y          = '0;
      out_nxt.out_u          = '0;
      out_nxt.out_v          = '0;
      out_nxt.batch_texture  = job_r.draw_tex;
      out_nxt.batch_color    = job_r.draw_col;
      out_nxt.batch_vertices = job_r.draw_cnt;
    end else begin
      out_nxt.kind           = sba_pkg::KIND_VERTEX;
      out_nxt.out_x          = job_r.vtx[vsel].x;
      out_nxt.out_y          = job_r.vtx[vsel].y;
      out_nxt.out_u          = job_r.vtx[vsel].u;
      out_nxt.out_v          = job_r.vtx[vsel].v;
      out_nxt.batch_texture  = '0;
      out_nxt.batch_color    = '0;
      out_nxt.batch_vertices = '0;
    end
    out_nxt.last = is_last;

    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    job_valid_nxt = job_valid_r;
    if (out_load) begin
      out_valid_nxt = job_valid_r;
      if (job_valid_r) begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    // free slot: drop the finished job and take the next one in the same edge
    if (job_free) begin
      job_valid_nxt = job_load;
      idx_nxt       = 2'd0;
    end
    job_nxt = job_load && job_free ? job_in : job_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (out_load && job_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/sprite_batch_triangle_assembler.sv */
// Sprite batch triangle assembler, top level.
// Instantiates sba_assemble and sba_emit; types and codes come from sba_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one sprite vertex or a flush
//   request per beat. Result channel (out_valid / out_stall / out_data): list
//   vertices and draw commands, one beat per cycle while out_stall is low,
//   last set on the final beat an input produced.
//   Path: an accepted item's job record is registered in the job slot, and
//   its first result then enters the output register once that is free.
//   Throughput: an item has 0 to 4 results, a draw command when one is due
//   and then 3 vertices for a fan or strip triangle or 1 for a list vertex.
//   An item with results holds the single job slot until its last result
//   enters the output register, one result per cycle while out_stall is low.
//   The next item is taken in the cycle the last result of the current one
//   enters the output register, so there is no gap between items.
//   Reset: sprite position, batch count, texture and colour return to zero and
//   both channels go empty.
//   Stall: out_stall holds the output register; the job slot then fills and
//   in_stall rises until results drain.
`default_nettype none

module sprite_batch_triangle_assembler #(
  parameter int BATCH_CAPACITY = sba_pkg::BATCH_CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sba_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sba_pkg::out_beat_t     out_data
);

  sba_pkg::job_t job;
  logic          job_nonempty;
  logic          job_free;
  logic          accept;

  assign in_stall = !job_free;
  assign accept   = in_valid && job_free;

  sba_assemble #(
    .BATCH_CAPACITY(BATCH_CAPACITY)
  ) u_assemble (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_beat      (in_data),
    .job          (job),
    .job_nonempty (job_nonempty)
  );

  sba_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (accept && job_nonempty),
    .job_in    (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_sprite_batch_triangle_assembler.sv */
// Self-checking testbench for sprite_batch_triangle_assembler: a scoreboard class predicts
// the list vertices and draw commands for each accepted beat and checks every result beat.
// Depends on sba_pkg for the beat structs and the func, mode and kind codes.
`default_nettype none

module tb_sprite_batch_triangle_assembler;

  localparam int CAPACITY = sba_pkg::BATCH_CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 460;
  localparam int MIXED_MIN = 24;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class batch_scoreboard;
    sba_pkg::vertex_t first_v, back2_v, prev_v;
    int unsigned vpos, batch_cnt, scount;
    logic [1:0] smode;
    logic [15:0] btex;
    logic [31:0] bcol;
    sba_pkg::out_beat_t step_q[$];
    sba_pkg::out_beat_t expected_q[$];
    int errors;
    int capacity_draws;

    function new();
      first_v = '0;
      back2_v = '0;
      prev_v = '0;
      vpos = 0;
      batch_cnt = 0;
      scount = 0;
      smode = sba_pkg::MODE_FAN;
      btex = '0;
      bcol = '0;
      errors = 0;
      capacity_draws = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_draw();
      sba_pkg::out_beat_t r;
      if (batch_cnt != 0) begin
        r = '0;
        r.kind = sba_pkg::KIND_DRAW;
        r.batch_texture = btex;
        r.batch_color = bcol;
        r.batch_vertices = batch_cnt[10:0];
        step_q.push_back(r);
      end
      batch_cnt = 0;
    endfunction

    function void push_vertex(sba_pkg::vertex_t v);
      sba_pkg::out_beat_t r;
      r = '0;
      r.kind = sba_pkg::KIND_VERTEX;
      r.out_x = v.x;
      r.out_y = v.y;
      r.out_u = v.u;
      r.out_v = v.v;
      step_q.push_back(r);
      batch_cnt++;
    endfunction

    function void note_input(sba_pkg::in_beat_t b);
      sba_pkg::vertex_t cur;
      int unsigned cnt, p;
      sba_pkg::out_beat_t r;
      step_q.delete();
      if (b.func == sba_pkg::FUNC_FLUSH) begin
        push_draw();
      end else begin
        cur = {b.pos_x, b.pos_y, b.tex_u, b.tex_v};
        cnt = 32'(b.sprite_vertex_count);
        if (cnt < 32'(sba_pkg::SPRITE_CNT_MIN)) cnt = 32'(sba_pkg::SPRITE_CNT_MIN);
        if (cnt > 32'(sba_pkg::SPRITE_CNT_MAX)) cnt = 32'(sba_pkg::SPRITE_CNT_MAX);
        p = vpos;
        // sprite parameters are latched on its first vertex only
        if (p == 0) begin
          if (batch_cnt != 0 && (b.texture_id != btex || b.color_key != bcol ||
              batch_cnt + 3 * (cnt - 2) >= CAPACITY)) begin
            if (b.texture_id == btex && b.color_key == bcol) capacity_draws++;
            push_draw();
          end
          btex = b.texture_id;
          bcol = b.color_key;
          scount = cnt;
          smode = b.primitive_mode;
          first_v = cur;
        end
        if (smode == sba_pkg::MODE_LIST) begin
          push_vertex(cur);
        end else if ((smode == sba_pkg::MODE_FAN || smode == sba_pkg::MODE_STRIP) && p >= 2) begin
          push_vertex(smode == sba_pkg::MODE_FAN ? first_v : back2_v);
          push_vertex(prev_v);
          push_vertex(cur);
        end
        back2_v = prev_v;
        prev_v = cur;
        vpos = (p + 1 >= scount) ? 0 : p + 1;
      end
      foreach (step_q[i]) begin
        r = step_q[i];
        r.last = (i == step_q.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void cmp(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, nm, e, a);
      end
    endfunction

    function void check_result(sba_pkg::out_beat_t a);
      sba_pkg::out_beat_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, a);
        return;
      end
      e = expected_q.pop_front();
      cmp("kind", 32'(e.kind), 32'(a.kind));
      cmp("out_x", e.out_x, a.out_x);
      cmp("out_y", e.out_y, a.out_y);
      cmp("out_u", e.out_u, a.out_u);
      cmp("out_v", e.out_v, a.out_v);
      cmp("batch_texture", 32'(e.batch_texture), 32'(a.batch_texture));
      cmp("batch_color", e.batch_color, a.batch_color);
      cmp("batch_vertices", 32'(e.batch_vertices), 32'(a.batch_vertices));
      cmp("last", 32'(e.last), 32'(a.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sba_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sba_pkg::out_beat_t out_data;

  batch_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;

  sprite_batch_triangle_assembler #(
    .BATCH_CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic sba_pkg::in_beat_t make_vertex(logic [15:0] tex, logic [31:0] col,
                                                    logic [1:0] mode, logic [3:0] cnt);
    sba_pkg::in_beat_t b;
    b.func = sba_pkg::FUNC_VERTEX;
    b.pos_x = $urandom;
    b.pos_y = $urandom;
    b.tex_u = $urandom;
    b.tex_v = $urandom;
    b.texture_id = tex;
    b.color_key = col;
    b.primitive_mode = mode;
    b.sprite_vertex_count = cnt;
    return b;
  endfunction

  function automatic sba_pkg::in_beat_t make_stray();
    return make_vertex(16'($urandom), $urandom, 2'($urandom), 4'($urandom));
  endfunction

  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_item(sba_pkg::in_beat_t b);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    items_sent++;
  endtask

  task automatic send_flush();
    sba_pkg::in_beat_t b;
    b = make_stray();
    b.func = sba_pkg::FUNC_FLUSH;
    send_item(b);
  endtask

  // Send one whole sprite; later vertices may carry stray fields, and flushes may cut in.
  task automatic send_sprite(logic [15:0] tex, logic [31:0] col, logic [1:0] mode,
                             logic [3:0] cnt, int noise_pct, int flush_pct);
    sba_pkg::in_beat_t b;
    int n;
    n = cnt < sba_pkg::SPRITE_CNT_MIN ? int'(sba_pkg::SPRITE_CNT_MIN) :
        (cnt > sba_pkg::SPRITE_CNT_MAX ? int'(sba_pkg::SPRITE_CNT_MAX) : int'(cnt));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 99) < noise_pct)
        b = make_stray();
      else
        b = make_vertex(tex, col, mode, cnt);
      send_item(b);
      if ($urandom_range(0, 99) < flush_pct) send_flush();
    end
  endtask

  // Hold the sender until every expected beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: runs of ready and stalled cycles, mostly short.
  initial begin
    int len;
    logic stall;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 99) >= 60;
      if (stall)
        len = int'($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
      else
        len = int'($urandom_range(0, 9) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 8));
      out_stall <= stall;
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    sba_pkg::in_beat_t b;
    logic [15:0] tex;
    logic [31:0] col;
    logic [1:0] mode;
    logic [3:0] cnt;
    int dense_end, target;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flush with nothing batched: no beat
    send_flush();
    // fan at the field extremes
    b = make_vertex(16'hFFFF, 32'hFFFF_FFFF, sba_pkg::MODE_FAN, 4'd3);
    {b.pos_x, b.pos_y, b.tex_u, b.tex_v} = '1;
    send_item(b);
    b = make_vertex(16'hFFFF, 32'hFFFF_FFFF, sba_pkg::MODE_FAN, 4'd3);
    {b.pos_x, b.pos_y, b.tex_u, b.tex_v} = '0;
    send_item(b);
    send_item(make_vertex(16'hFFFF, 32'hFFFF_FFFF, sba_pkg::MODE_FAN, 4'd3));
    // strip on a new texture, later vertices carrying stray fields
    send_sprite(16'h0001, 32'hFFFF_FFFF, sba_pkg::MODE_STRIP, 4'd4, 100, 0);
    // list with a count below range, new colour
    send_sprite(16'h0001, 32'h0, sba_pkg::MODE_LIST, 4'd0, 0, 0);
    // fan cut by a flush in mid-sprite
    for (int i = 0; i < 5; i++) begin
      send_item(make_vertex(16'h0001, 32'h0, sba_pkg::MODE_FAN, 4'd5));
      if (i == 2) send_flush();
    end
    // unused mode with a count above range, then a flush of the emptied batch
    send_sprite(16'hA5A5, $urandom, MODE_UNUSED, 4'd15, 0, 0);
    send_flush();
    drain();

    // long run of full fan and strip sprites on one texture and colour until the
    // batch overflows on capacity
    tex = 16'($urandom);
    col = $urandom;
    while (sb.capacity_draws == 0) begin
      mode = $urandom_range(0, 1) ? sba_pkg::MODE_FAN : sba_pkg::MODE_STRIP;
      cnt = 4'($urandom_range(8, 15));
      send_sprite(tex, col, mode, cnt, 20, 0);
    end
    drain();

    // mixed sprites, texture and colour changes, flushes anywhere
    dense_end = items_sent;
    target = dense_end + MIXED_MIN > RANDOM_ITEMS ? dense_end + MIXED_MIN : RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) >= 60) tex = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) >= 60) col = $urandom;
      mode = $urandom_range(0, 9) == 0 ? MODE_UNUSED : 2'($urandom_range(0, 2));
      cnt = 4'($urandom_range(0, 99) < 15 ? $urandom_range(0, 15) : $urandom_range(3, 8));
      if ($urandom_range(0, 9) == 0) send_flush();
      send_sprite(tex, col, mode, cnt, 15, 6);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
